### rtl/core/csc_pkg.sv
// Shared types and constants for the conflict serializability checker.
// Depends on nothing; imported by the controller, datapath and top level.
package csc_pkg;

  localparam int TXN_W     = 7;
  localparam int ITEM_W    = 16;
  localparam int FLAGS_W   = 64;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic REG_NUM_TXNS = 1'b0;
  localparam logic [TXN_W-1:0] NUM_TXNS_RST = 7'd64;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_CHECK,
    CMD_SCAN,
    CMD_APPEND,
    CMD_EDGE_RD,
    CMD_EDGE_WR,
    CMD_DFS_INIT,
    CMD_ROOT,
    CMD_STEP,
    CMD_POP,
    CMD_EMIT
  } dp_cmd_t;

  typedef struct packed {
    logic op_ok;
    logic last;
    logic scan_done;
    logic from_empty;
    logic root_done;
    logic root_visited;
    logic cand_nz;
    logic sp_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/core/csc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module csc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/csc_datapath.sv
// Datapath: operation buffer, precedence graph rows, DFS stack and result register.
// Depends on csc_pkg and csc_ram; driven by commands from csc_ctrl.
module csc_datapath #(
  parameter int MAX_TXNS  = 64,
  parameter int MAX_OPS   = 256,
  parameter int ITEM_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [csc_pkg::TXN_W-1:0]     num_txns,
  input  logic [csc_pkg::TXN_W-1:0]     in_txn_id,
  input  logic                          in_is_write,
  input  logic [csc_pkg::ITEM_W-1:0]    in_item_id,
  input  logic                          in_last_op,
  input  csc_pkg::dp_cmd_t              cmd,
  output csc_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csc_pkg::FLAGS_W-1:0]   out_cycle_flags,
  output logic                          out_any_cycle,
  output logic                          out_input_error
);
  import csc_pkg::*;

  localparam int TW  = $clog2(MAX_TXNS);
  localparam int AW  = $clog2(MAX_OPS);
  localparam int CW  = $clog2(MAX_OPS + 1);
  localparam int SPW = $clog2(MAX_TXNS + 1);
  localparam int IW  = (ITEM_BITS < ITEM_W) ? ITEM_BITS : ITEM_W;
  localparam int OW  = TW + 1 + IW;

  logic [TXN_W-1:0]    txn_r;
  logic                wr_r;
  logic [IW-1:0]       item_r;
  logic                last_r;
  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       k_r;
  logic                cmp_v_r;
  logic [MAX_TXNS-1:0] from_r;
  logic                err_r;
  logic [TW-1:0]       edge_f_r;
  logic [MAX_TXNS-1:0] adj_vld_r;
  logic                adj_rvld_r;
  logic [MAX_TXNS-1:0] visited_r;
  logic [MAX_TXNS-1:0] onstack_r;
  logic [MAX_TXNS-1:0] flags_r;
  logic [SPW-1:0]      root_r;
  logic [TW-1:0]       top_r;
  logic [SPW-1:0]      sp_r;
  logic                out_valid_r;
  logic [FLAGS_W-1:0]  out_flags_r;
  logic                out_any_r;
  logic                out_err_r;

  logic [TXN_W-1:0]    n_eff;
  logic [MAX_TXNS-1:0] nmask;
  logic [TW-1:0]       txn_idx;
  logic                op_ok;
  logic [OW-1:0]       op_rd;
  logic                match;
  logic [MAX_TXNS-1:0] adj_rd;
  logic [MAX_TXNS-1:0] row;
  logic [MAX_TXNS-1:0] cand;
  logic [TW-1:0]       cand_idx;
  logic [TW-1:0]       from_idx;
  logic [MAX_TXNS-1:0] top_bit;
  logic [MAX_TXNS-1:0] hits;
  logic [TW-1:0]       root_idx;
  logic                root_done;
  logic                root_visited;
  logic                op_re;
  logic                op_we;
  logic                adj_re;
  logic [TW-1:0]       adj_raddr;
  logic                adj_we;
  logic [TW-1:0]       stk_rd;
  logic                stk_we;
  logic                stk_re;

  function automatic logic [TW-1:0] ffs(input logic [MAX_TXNS-1:0] v);
    logic [TW-1:0] r;
    r = '0;
    for (int j = MAX_TXNS - 1; j >= 0; j--) begin
      if (v[j]) begin
        r = TW'(j);
      end
    end
    return r;
  endfunction

  assign n_eff = (num_txns > TXN_W'(MAX_TXNS)) ? TXN_W'(MAX_TXNS) : num_txns;

  always_comb begin
    for (int j = 0; j < MAX_TXNS; j++) begin
      nmask[j] = (TXN_W'(j) < n_eff);
    end
  end

  assign txn_idx = TW'(txn_r - TXN_W'(1));
  assign op_ok   = (txn_r != '0) && (txn_r <= n_eff) && (cnt_r < CW'(MAX_OPS));
  assign match   = cmp_v_r && (op_rd[OW-1 -: TW] != txn_idx) && (op_rd[IW-1:0] == item_r)
                   && (op_rd[IW] || wr_r);

  assign row      = adj_rvld_r ? adj_rd : '0;
  assign cand     = row & ~visited_r & nmask;
  assign cand_idx = ffs(cand);
  assign from_idx = ffs(from_r);
  assign top_bit  = MAX_TXNS'(1) << top_r;
  assign hits     = row & onstack_r & ~top_bit & nmask;
  assign root_idx = root_r[TW-1:0];
  assign root_done    = (TXN_W'(root_r) >= n_eff);
  assign root_visited = visited_r[root_idx];

  assign op_re  = (cmd == CMD_SCAN) && (k_r < cnt_r);
  assign op_we  = (cmd == CMD_APPEND);
  assign stk_we = (cmd == CMD_STEP) && (cand != '0);
  assign stk_re = (cmd == CMD_STEP) && (cand == '0) && (sp_r != SPW'(1));
  assign adj_we = (cmd == CMD_EDGE_WR);

  always_comb begin
    adj_re    = 1'b0;
    adj_raddr = '0;
    case (cmd)
      CMD_EDGE_RD: begin
        adj_re    = (from_r != '0);
        adj_raddr = from_idx;
      end
      CMD_ROOT: begin
        adj_re    = !root_done && !root_visited;
        adj_raddr = root_idx;
      end
      CMD_STEP: begin
        adj_re    = (cand != '0);
        adj_raddr = cand_idx;
      end
      CMD_POP: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rd;
      end
      default: begin
        adj_re    = 1'b0;
        adj_raddr = '0;
      end
    endcase
  end

  csc_ram #(.WIDTH(OW), .DEPTH(MAX_OPS)) u_op_ram (
    .clk   (clk),
    .we    (op_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata ({txn_idx, wr_r, item_r}),
    .re    (op_re),
    .raddr (k_r[AW-1:0]),
    .rdata (op_rd)
  );

  csc_ram #(.WIDTH(MAX_TXNS), .DEPTH(MAX_TXNS)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (edge_f_r),
    .wdata (row | (MAX_TXNS'(1) << txn_idx)),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rd)
  );

  csc_ram #(.WIDTH(TW), .DEPTH(MAX_TXNS)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (TW'(sp_r - SPW'(1))),
    .wdata (top_r),
    .re    (stk_re),
    .raddr (TW'(sp_r - SPW'(2))),
    .rdata (stk_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      k_r         <= '0;
      cmp_v_r     <= 1'b0;
      err_r       <= 1'b0;
      adj_vld_r   <= '0;
      adj_rvld_r  <= 1'b0;
      sp_r        <= '0;
      root_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adj_re) begin
        adj_rvld_r <= adj_vld_r[adj_raddr];
      end
      if (cmd == CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_ACCEPT: begin
          txn_r  <= in_txn_id;
          wr_r   <= in_is_write;
          item_r <= in_item_id[IW-1:0];
          last_r <= in_last_op;
        end
        CMD_CHECK: begin
          if (!op_ok) begin
            err_r <= 1'b1;
          end
          k_r     <= '0;
          cmp_v_r <= 1'b0;
          from_r  <= '0;
        end
        CMD_SCAN: begin
          if (op_re) begin
            k_r <= k_r + CW'(1);
          end
          cmp_v_r <= op_re;
          if (match) begin
            from_r[op_rd[OW-1 -: TW]] <= 1'b1;
          end
        end
        CMD_APPEND: begin
          cnt_r <= cnt_r + CW'(1);
        end
        CMD_EDGE_RD: begin
          edge_f_r <= from_idx;
        end
        CMD_EDGE_WR: begin
          from_r[edge_f_r]    <= 1'b0;
          adj_vld_r[edge_f_r] <= 1'b1;
        end
        CMD_DFS_INIT: begin
          visited_r <= '0;
          onstack_r <= '0;
          flags_r   <= '0;
          root_r    <= '0;
        end
        CMD_ROOT: begin
          if (!root_done) begin
            root_r <= root_r + SPW'(1);
            if (!root_visited) begin
              top_r               <= root_idx;
              sp_r                <= SPW'(1);
              visited_r[root_idx] <= 1'b1;
              onstack_r[root_idx] <= 1'b1;
            end
          end
        end
        CMD_STEP: begin
          if (cand != '0) begin
            top_r               <= cand_idx;
            sp_r                <= sp_r + SPW'(1);
            visited_r[cand_idx] <= 1'b1;
            onstack_r[cand_idx] <= 1'b1;
          end else begin
            flags_r          <= flags_r | hits | ((hits != '0) ? top_bit : '0);
            onstack_r[top_r] <= 1'b0;
            sp_r             <= sp_r - SPW'(1);
          end
        end
        CMD_POP: begin
          top_r <= stk_rd;
        end
        CMD_EMIT: begin
          out_flags_r <= FLAGS_W'(flags_r);
          out_any_r   <= (flags_r != '0);
          out_err_r   <= err_r;
          cnt_r       <= '0;
          adj_vld_r   <= '0;
          err_r       <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.op_ok        = op_ok;
  assign status.last         = last_r;
  assign status.scan_done    = (k_r == cnt_r) && !cmp_v_r;
  assign status.from_empty   = (from_r == '0);
  assign status.root_done    = root_done;
  assign status.root_visited = root_visited;
  assign status.cand_nz      = (cand != '0);
  assign status.sp_last      = (sp_r == SPW'(1));
  assign status.out_free     = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_cycle_flags = out_flags_r;
  assign out_any_cycle   = out_any_r;
  assign out_input_error = out_err_r;

endmodule

### rtl/core/csc_ctrl.sv
// Controller state machine: sequences accept, scan, edge insert, DFS and emit.
// Depends on csc_pkg; drives csc_datapath through commands.
module csc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csc_pkg::dp_status_t  status,
  output csc_pkg::dp_cmd_t     cmd
);
  import csc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_APPEND,
    S_EDGE_RD,
    S_EDGE_WR,
    S_DFS_INIT,
    S_ROOT,
    S_STEP,
    S_POP,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_ACCEPT;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd = CMD_CHECK;
        if (status.op_ok) begin
          state_nxt = S_SCAN;
        end else if (status.last) begin
          state_nxt = S_DFS_INIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (status.scan_done) begin
          state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd       = CMD_APPEND;
        state_nxt = S_EDGE_RD;
      end
      S_EDGE_RD: begin
        cmd = CMD_EDGE_RD;
        if (!status.from_empty) begin
          state_nxt = S_EDGE_WR;
        end else if (status.last) begin
          state_nxt = S_DFS_INIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EDGE_WR: begin
        cmd       = CMD_EDGE_WR;
        state_nxt = S_EDGE_RD;
      end
      S_DFS_INIT: begin
        cmd       = CMD_DFS_INIT;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd = CMD_ROOT;
        if (status.root_done) begin
          state_nxt = S_EMIT;
        end else if (!status.root_visited) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd = CMD_STEP;
        if (status.cand_nz) begin
          state_nxt = S_STEP;
        end else if (status.sp_last) begin
          state_nxt = S_ROOT;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        cmd       = CMD_POP;
        state_nxt = S_STEP;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd       = CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/conflict_serializability_checker_unit.sv
// Per kept operation: a scan of the operation buffer, one read per cycle from the buffer
// RAM, then an append, plus an edge read and an edge write per distinct conflicting
// earlier transaction; a dropped operation skips the scan and the edge insert.
// On the last operation a DFS runs over the n vertices, and the result waits out any
// stall on the result register; one operation is in work at a time.
// rst_n is synchronous, active low: clears counts, row valid bits, result valid; count = 64.
module conflict_serializability_checker_unit #(
  parameter int MAX_TXNS  = 64,
  parameter int MAX_OPS   = 256,
  parameter int ITEM_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csc_pkg::APB_AW-1:0]    paddr,
  input  logic [csc_pkg::APB_DW-1:0]    pwdata,
  output logic [csc_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csc_pkg::TXN_W-1:0]     in_txn_id,
  input  logic                          in_is_write,
  input  logic [csc_pkg::ITEM_W-1:0]    in_item_id,
  input  logic                          in_last_op,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csc_pkg::FLAGS_W-1:0]   out_cycle_flags,
  output logic                          out_any_cycle,
  output logic                          out_input_error
);
  import csc_pkg::*;

  logic [TXN_W-1:0] num_r;
  logic             reg_sel;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_NUM_TXNS);
  assign prdata  = reg_sel ? APB_DW'(num_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r <= NUM_TXNS_RST;
    end else if (psel && penable && pwrite && reg_sel) begin
      num_r <= pwdata[TXN_W-1:0];
    end
  end

  csc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csc_datapath #(
    .MAX_TXNS  (MAX_TXNS),
    .MAX_OPS   (MAX_OPS),
    .ITEM_BITS (ITEM_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .num_txns        (num_r),
    .in_txn_id       (in_txn_id),
    .in_is_write     (in_is_write),
    .in_item_id      (in_item_id),
    .in_last_op      (in_last_op),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cycle_flags (out_cycle_flags),
    .out_any_cycle   (out_any_cycle),
    .out_input_error (out_input_error)
  );

endmodule

### rtl/core/csc_checker.sv
// Port-level assertions for the checker unit, bound to the top level.
// Depends on csc_pkg for port widths.
module csc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        pready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [csc_pkg::FLAGS_W-1:0] out_cycle_flags,
  input logic                        out_any_cycle
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cycle_flags))
    else $error("result changed while stalled");

  a_any_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_any_cycle == (out_cycle_flags != '0)))
    else $error("any_cycle disagrees with flags");

  a_pair_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones(out_cycle_flags) != 1))
    else $error("back edge flagged a single endpoint");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid && pready)
    else $error("result valid after reset");

endmodule

bind conflict_serializability_checker_unit csc_checker u_csc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .pready          (pready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_cycle_flags (out_cycle_flags),
  .out_any_cycle   (out_any_cycle)
);

### tb/sv/csc_scoreboard.sv
// Watches the operation and result channels of the serializability checker,
// predicts each result with its own precedence-graph model and compares it.
// Depends on csc_pkg; the number of vertices is fed in by the testbench top.
module csc_scoreboard (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [csc_pkg::TXN_W-1:0]   num_txns,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [csc_pkg::TXN_W-1:0]   in_txn_id,
  input  logic                        in_is_write,
  input  logic [csc_pkg::ITEM_W-1:0]  in_item_id,
  input  logic                        in_last_op,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [csc_pkg::FLAGS_W-1:0] out_cycle_flags,
  input  logic                        out_any_cycle,
  input  logic                        out_input_error,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 64;
  localparam int NOPS = 256;

  typedef struct packed {
    logic [63:0] flags;
    logic        any;
    logic        err;
  } verdict_t;

  verdict_t verdict_q[$];
  logic [6:0]  sched_txn[NOPS];
  logic        sched_wr[NOPS];
  logic [15:0] sched_item[NOPS];
  int          sched_len;
  logic [63:0] prec[NV];
  logic        dropped;

  assign pending = verdict_q.size();

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic logic [63:0] back_edge_flags(input int n);
    logic [63:0] seen;
    int rank[NV];
    int stk_v[NV];
    int stk_nx[NV];
    int sp, r, v, i;
    logic [63:0] fl;
    seen = '0;
    r = 0;
    fl = '0;
    for (int k = 0; k < NV; k++) rank[k] = 0;
    for (int root = 0; root < n; root++) begin
      if (!seen[root]) begin
        seen[root] = 1'b1;
        stk_v[0] = root;
        stk_nx[0] = 0;
        sp = 1;
        while (sp > 0) begin
          v = stk_v[sp-1];
          i = stk_nx[sp-1];
          while (i < n && !(prec[v][i] && !seen[i])) i++;
          if (i < n && sp < NV) begin
            stk_nx[sp-1] = i + 1;
            seen[i] = 1'b1;
            stk_v[sp] = i;
            stk_nx[sp] = 0;
            sp++;
          end else begin
            rank[v] = r & 63;
            r++;
            sp--;
          end
        end
      end
    end
    for (int a = 0; a < n; a++)
      for (int b = 0; b < n; b++)
        if (prec[a][b] && rank[a] < rank[b]) begin
          fl[a] = 1'b1;
          fl[b] = 1'b1;
        end
    return fl;
  endfunction

  always @(posedge clk) begin
    int n;
    verdict_t got, want;
    if (!rst_n) begin
      sched_len = 0;
      dropped = 1'b0;
      fail_count = 0;
      for (int k = 0; k < NV; k++) prec[k] = '0;
      verdict_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        n = (num_txns > NV) ? NV : num_txns;
        if (in_txn_id == 0 || in_txn_id > n || sched_len >= NOPS) begin
          dropped = 1'b1;
        end else begin
          for (int k = 0; k < sched_len; k++)
            if (sched_txn[k] != in_txn_id && sched_item[k] == in_item_id &&
                (sched_wr[k] || in_is_write))
              prec[sched_txn[k]-1][in_txn_id-1] = 1'b1;
          sched_txn[sched_len] = in_txn_id;
          sched_wr[sched_len] = in_is_write;
          sched_item[sched_len] = in_item_id;
          sched_len = sched_len + 1;
        end
        if (in_last_op) begin
          want.flags = back_edge_flags(n);
          want.any = |want.flags;
          want.err = dropped;
          verdict_q.push_back(want);
          sched_len = 0;
          dropped = 1'b0;
          for (int k = 0; k < NV; k++) prec[k] = '0;
        end
      end
      if (out_valid && out_ready) begin
        got = '{out_cycle_flags, out_any_cycle, out_input_error};
        if (verdict_q.size() == 0) begin
          report("unexpected transfer", got.flags, '0);
        end else begin
          want = verdict_q.pop_front();
          if (got.flags !== want.flags) report("cycle_flags", got.flags, want.flags);
          if (got.any !== want.any) report("any_cycle", got.any, want.any);
          if (got.err !== want.err) report("input_error", got.err, want.err);
        end
      end
    end
  end
endmodule

### tb/sv/tb_conflict_serializability_checker_unit.sv
// Stimulus and verdict for the conflict serializability checker unit.
// Depends on csc_pkg, the checker unit and the csc_scoreboard module.
module tb_conflict_serializability_checker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import csc_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [TXN_W-1:0] in_txn_id = '0;
  logic in_is_write = 1'b0;
  logic [ITEM_W-1:0] in_item_id = '0;
  logic in_last_op = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic [FLAGS_W-1:0] out_cycle_flags;
  logic out_any_cycle, out_input_error;
  logic [TXN_W-1:0] txn_limit = NUM_TXNS_RST;
  int fail_count, pending;
  int send_idle = 0, recv_idle = 0;
  int quiet = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  conflict_serializability_checker_unit dut (.*);

  csc_scoreboard chk (
    .clk, .rst_n, .num_txns(txn_limit),
    .in_valid, .in_ready, .in_txn_id, .in_is_write, .in_item_id, .in_last_op,
    .out_valid, .out_ready, .out_cycle_flags, .out_any_cycle, .out_input_error,
    .fail_count, .pending
  );

  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic write_txn_count(input logic [6:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_NUM_TXNS, 2'b00}; pwdata <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    txn_limit <= val;
  endtask

  task automatic send_op(input logic [6:0] t, input logic w, input logic [15:0] it,
                         input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_txn_id <= t; in_is_write <= w; in_item_id <= it; in_last_op <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic random_schedule(input int ntx, input int len);
    int t;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) t = $urandom_range(127);
      else t = $urandom_range(ntx, 1);
      send_op(7'(t), 1'($urandom_range(1)),
              ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5)),
              k == len - 1);
    end
  endtask

  initial begin
    int ops;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: classic cycle, ok chains, bad ids, extremes
    send_op(1, 0, 16'h0000, 0);
    send_op(2, 1, 16'h0000, 0);
    send_op(2, 0, 16'hFFFF, 0);
    send_op(1, 1, 16'hFFFF, 1);
    send_op(1, 0, 7, 0);
    send_op(2, 0, 7, 0);
    send_op(64, 1, 7, 1);
    send_op(0, 1, 3, 0);
    send_op(65, 0, 3, 0);
    send_op(127, 1, 3, 1);
    send_op(64, 1, 16'hAAAA, 0);
    send_op(1, 1, 16'hAAAA, 0);
    send_op(64, 0, 16'hAAAA, 1);
    send_op(0, 0, 0, 1);
    drain();
    write_txn_count(2);
    send_op(3, 1, 1, 0);
    send_op(1, 1, 1, 0);
    send_op(2, 1, 1, 1);
    drain();
    write_txn_count(0);
    send_op(1, 1, 1, 1);
    drain();
    write_txn_count(127);
    send_op(1, 1, 9, 0);
    send_op(64, 1, 9, 1);
    drain();
    write_txn_count(1);
    for (int k = 0; k < 258; k++) send_op(1, k[0], 16'(k), k == 257);
    drain();
    // random phases with different counts and idling patterns
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 38 : (ph == 1) ? 57 : 0;
      recv_idle = (ph == 0) ? 57 : (ph == 1) ? 38 : 0;
      write_txn_count(ph == 0 ? 4 : ph == 1 ? 64 : 8);
      ops = 0;
      while (ops < 75) begin
        int len;
        len = $urandom_range(12, 1);
        random_schedule(ph == 1 ? $urandom_range(64, 2) : txn_limit, len);
        ops += len;
      end
      drain();
    end
    if (fail_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
